// ===== sv/lobm_pkg.sv =====
// ============================================================================
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ============================================================================
`default_nettype none

package lobm_pkg;

    localparam int ORDERS_PER_SIDE_DEF = 64;
    localparam int MAX_RESULTS         = 64;
    localparam int RES_AW              = $clog2(MAX_RESULTS);

    localparam logic [1:0] ACT_LIMIT  = 2'd0;
    localparam logic [1:0] ACT_MARKET = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;

    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_RESTED = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic        side;
        logic [31:0] limit_price;
        logic [31:0] order_qty;
        logic [31:0] order_ref;
        logic [63:0] time_ns;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] taker_id;
        logic [31:0] maker_id;
        logic        trade_side;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic [63:0] trade_time;
        logic        last;
        logic [31:0] bid_top;
        logic [31:0] ask_top;
        logic [32:0] mid_twice;
    } out_item_t;

    // One resting order in the book.
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] id;
    } entry_t;

    // One fill as kept in the trade buffer.
    typedef struct packed {
        logic [31:0] maker_id;
        logic [31:0] price;
        logic [31:0] qty;
    } trade_t;

    typedef struct packed {
        logic              we;
        logic [RES_AW-1:0] addr;
        trade_t            data;
    } trade_wr_t;

    // Closing summary of one item, handed over when the book work is done.
    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [RES_AW-1:0] nres;
        logic [31:0]       taker_id;
        logic              side;
        logic [63:0]       time_ns;
        logic [31:0]       bid_top;
        logic [31:0]       ask_top;
        logic [32:0]       mid_twice;
    } summary_t;

endpackage

`default_nettype wire

// ===== sv/lobm_engine.sv =====
// ============================================================================
// lobm_engine
// Book memory and the sequencer that matches, rests and cancels orders.
// ============================================================================
`default_nettype none

module lobm_engine #(
    parameter int ORDERS_PER_SIDE = lobm_pkg::ORDERS_PER_SIDE_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lobm_pkg::in_item_t  in_item,
    input  wire logic                res_idle,
    output lobm_pkg::trade_wr_t      trade_wr,
    output lobm_pkg::summary_t       summary
);
    import lobm_pkg::*;

    localparam int AW = (ORDERS_PER_SIDE > 1) ? $clog2(ORDERS_PER_SIDE) : 1;
    localparam int CW = $clog2(ORDERS_PER_SIDE + 1);
    localparam logic [AW:0]   N_W   = (AW + 1)'(ORDERS_PER_SIDE);
    localparam logic [CW-1:0] N_C   = CW'(ORDERS_PER_SIDE);
    localparam logic [AW-1:0] LASTI = AW'(ORDERS_PER_SIDE - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_M_CHECK, S_M_EVAL, S_M_END,
        S_R_CHECK, S_R_EVAL, S_R_INS, S_C_CHECK, S_C_EVAL,
        S_FIN, S_FIN_B, S_FIN_A
    } state_t;

    state_t            state_reg;
    logic [1:0]        act_reg;
    logic              side_reg;
    logic [31:0]       lim_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       oid_reg;
    logic [63:0]       time_reg;
    logic [RES_AW-1:0] nfill_reg;
    logic              more_reg;
    logic [1:0]        status_reg;
    logic [CW-1:0]     count_reg [0:1];
    logic [AW-1:0]     head_reg  [0:1];
    logic [AW-1:0]     ridx_reg;
    logic              cs_reg;
    logic [CW-1:0]     rd_reg;
    logic [CW-1:0]     wr_reg;
    logic [31:0]       bb_reg;

    entry_t mem [0:1][0:ORDERS_PER_SIDE-1];
    entry_t rdata_reg;

    logic          mem_we;
    logic          ws, rs;
    logic [AW-1:0] wi, ri;
    entry_t        wdata;

    logic        opp, own, is_mkt, m_stop, m_full, worse, keep;
    logic [31:0] fill_q, newq, ask_best;

    // Logical position k behind the head of a side, wrapped into the memory.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] k);
        logic [AW:0] sum;
        sum = {1'b0, h} + {1'b0, k};
        if (sum >= N_W)
        begin
            sum = sum - N_W;
        end
        return sum[AW-1:0];
    endfunction

    assign opp    = ~side_reg;
    assign own    = side_reg;
    assign is_mkt = (act_reg == ACT_MARKET);
    assign m_stop = !is_mkt && (side_reg ? (lim_reg > rdata_reg.price)
                                         : (lim_reg < rdata_reg.price));
    assign m_full = (nfill_reg == RES_AW'(MAX_RESULTS - 1));
    assign fill_q = (rem_reg < rdata_reg.qty) ? rem_reg : rdata_reg.qty;
    assign newq   = rdata_reg.qty - fill_q;
    assign worse  = own ? (rdata_reg.price > lim_reg) : (rdata_reg.price < lim_reg);
    assign keep   = (rdata_reg.id != oid_reg);
    assign ask_best = (count_reg[1] != '0) ? rdata_reg.price : 32'd0;

    assign in_ready = (state_reg == S_IDLE) && res_idle;

    always_comb
    begin
        mem_we = 1'b0;
        ws     = 1'b0;
        wi     = '0;
        wdata  = rdata_reg;
        rs     = 1'b0;
        ri     = '0;
        trade_wr.we   = 1'b0;
        trade_wr.addr = nfill_reg;
        trade_wr.data = '{maker_id: rdata_reg.id, price: rdata_reg.price, qty: fill_q};
        unique case (state_reg)
            S_M_CHECK:
            begin
                rs = opp;
                ri = head_reg[opp];
            end
            S_M_EVAL:
            begin
                if (!m_stop && !m_full)
                begin
                    trade_wr.we = 1'b1;
                    if (newq != 32'd0)
                    begin
                        mem_we = 1'b1;
                        ws     = opp;
                        wi     = head_reg[opp];
                        wdata  = '{price: rdata_reg.price, qty: newq, id: rdata_reg.id};
                    end
                end
            end
            S_R_CHECK:
            begin
                rs = own;
                ri = phys(head_reg[own], ridx_reg - 1'b1);
            end
            S_R_EVAL:
            begin
                if (worse)
                begin
                    mem_we = 1'b1;
                    ws     = own;
                    wi     = phys(head_reg[own], ridx_reg);
                end
            end
            S_R_INS:
            begin
                mem_we = 1'b1;
                ws     = own;
                wi     = phys(head_reg[own], ridx_reg);
                wdata  = '{price: lim_reg, qty: rem_reg, id: oid_reg};
            end
            S_C_CHECK:
            begin
                rs = cs_reg;
                ri = phys(head_reg[cs_reg], rd_reg[AW-1:0]);
            end
            S_C_EVAL:
            begin
                if (keep && (wr_reg != rd_reg))
                begin
                    mem_we = 1'b1;
                    ws     = cs_reg;
                    wi     = phys(head_reg[cs_reg], wr_reg[AW-1:0]);
                end
            end
            S_FIN:
            begin
                rs = 1'b0;
                ri = head_reg[0];
            end
            S_FIN_B:
            begin
                rs = 1'b1;
                ri = head_reg[1];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        summary.valid     = (state_reg == S_FIN_A);
        summary.kind      = status_reg;
        summary.nres      = nfill_reg;
        summary.taker_id  = oid_reg;
        summary.side      = side_reg;
        summary.time_ns   = time_reg;
        summary.bid_top   = bb_reg;
        summary.ask_top   = ask_best;
        summary.mid_twice = ((count_reg[0] != '0) && (count_reg[1] != '0))
                            ? ({1'b0, bb_reg} + {1'b0, ask_best}) : 33'd0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ws][wi] <= wdata;
        end
        rdata_reg <= mem[rs][ri];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            nfill_reg    <= '0;
            more_reg     <= 1'b0;
            status_reg   <= KIND_NONE;
            cs_reg       <= 1'b0;
            rd_reg       <= '0;
            wr_reg       <= '0;
            ridx_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        act_reg    <= in_item.action;
                        side_reg   <= in_item.side;
                        lim_reg    <= in_item.limit_price;
                        rem_reg    <= in_item.order_qty;
                        oid_reg    <= in_item.order_ref;
                        time_reg   <= in_item.time_ns;
                        nfill_reg  <= '0;
                        more_reg   <= 1'b0;
                        status_reg <= KIND_NONE;
                        state_reg  <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (act_reg == ACT_CANCEL)
                    begin
                        cs_reg    <= 1'b0;
                        rd_reg    <= '0;
                        wr_reg    <= '0;
                        state_reg <= S_C_CHECK;
                    end
                    else if ((act_reg == ACT_LIMIT) || (act_reg == ACT_MARKET))
                    begin
                        state_reg <= S_M_CHECK;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_M_CHECK:
                begin
                    if ((rem_reg == 32'd0) || (count_reg[opp] == '0))
                    begin
                        state_reg <= S_M_END;
                    end
                    else
                    begin
                        state_reg <= S_M_EVAL;
                    end
                end
                S_M_EVAL:
                begin
                    if (m_stop)
                    begin
                        state_reg <= S_M_END;
                    end
                    else if (m_full)
                    begin
                        more_reg  <= 1'b1;
                        state_reg <= S_M_END;
                    end
                    else
                    begin
                        nfill_reg <= nfill_reg + 1'b1;
                        rem_reg   <= rem_reg - fill_q;
                        if (newq == 32'd0)
                        begin
                            head_reg[opp]  <= (head_reg[opp] == LASTI) ? '0
                                                                        : head_reg[opp] + 1'b1;
                            count_reg[opp] <= count_reg[opp] - 1'b1;
                        end
                        state_reg <= S_M_CHECK;
                    end
                end
                S_M_END:
                begin
                    state_reg <= S_FIN;
                    if ((rem_reg != 32'd0) && more_reg)
                    begin
                        status_reg <= KIND_FULL;
                    end
                    else if ((rem_reg != 32'd0) && !is_mkt)
                    begin
                        if (count_reg[own] == N_C)
                        begin
                            status_reg <= KIND_FULL;
                        end
                        else
                        begin
                            ridx_reg  <= count_reg[own][AW-1:0];
                            state_reg <= S_R_CHECK;
                        end
                    end
                end
                S_R_CHECK:
                begin
                    state_reg <= (ridx_reg == '0) ? S_R_INS : S_R_EVAL;
                end
                S_R_EVAL:
                begin
                    if (worse)
                    begin
                        ridx_reg  <= ridx_reg - 1'b1;
                        state_reg <= S_R_CHECK;
                    end
                    else
                    begin
                        state_reg <= S_R_INS;
                    end
                end
                S_R_INS:
                begin
                    count_reg[own] <= count_reg[own] + 1'b1;
                    status_reg     <= KIND_RESTED;
                    state_reg      <= S_FIN;
                end
                S_C_CHECK:
                begin
                    if (rd_reg == count_reg[cs_reg])
                    begin
                        count_reg[cs_reg] <= wr_reg;
                        if (!cs_reg)
                        begin
                            cs_reg <= 1'b1;
                            rd_reg <= '0;
                            wr_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        state_reg <= S_C_EVAL;
                    end
                end
                S_C_EVAL:
                begin
                    if (keep)
                    begin
                        wr_reg <= wr_reg + 1'b1;
                    end
                    rd_reg    <= rd_reg + 1'b1;
                    state_reg <= S_C_CHECK;
                end
                S_FIN:
                begin
                    state_reg <= S_FIN_B;
                end
                S_FIN_B:
                begin
                    bb_reg    <= (count_reg[0] != '0) ? rdata_reg.price : 32'd0;
                    state_reg <= S_FIN_A;
                end
                S_FIN_A:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/lobm_result.sv =====
// ============================================================================
// lobm_result
// Trade buffer and output register; plays back the results of one item.
// ============================================================================
`default_nettype none

module lobm_result (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lobm_pkg::trade_wr_t  trade_wr,
    input  wire lobm_pkg::summary_t   summary,
    output logic                      res_idle,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lobm_pkg::out_item_t       out_item
);
    import lobm_pkg::*;

    typedef enum logic [1:0] {
        RS_IDLE, RS_RD, RS_LD
    } state_t;

    state_t            state_reg;
    summary_t          sum_reg;
    logic [RES_AW-1:0] idx_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;
    trade_t            trade_mem [0:MAX_RESULTS-1];
    trade_t            rdata_reg;
    logic              slot_free;
    logic              ld_out;

    assign res_idle  = (state_reg == RS_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign ld_out    = (state_reg == RS_LD) && slot_free;

    always_ff @(posedge clk)
    begin
        if (trade_wr.we)
        begin
            trade_mem[trade_wr.addr] <= trade_wr.data;
        end
        rdata_reg <= trade_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= RS_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A taken result empties the register unless the next one lands now.
            if (out_valid_reg && out_ready && !ld_out)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                RS_IDLE:
                begin
                    if (summary.valid)
                    begin
                        sum_reg   <= summary;
                        idx_reg   <= '0;
                        state_reg <= RS_RD;
                    end
                end
                RS_RD:
                begin
                    state_reg <= RS_LD;
                end
                RS_LD:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.taker_id     <= sum_reg.taker_id;
                        out_reg.trade_side   <= sum_reg.side;
                        out_reg.trade_time   <= sum_reg.time_ns;
                        out_reg.bid_top      <= sum_reg.bid_top;
                        out_reg.ask_top      <= sum_reg.ask_top;
                        out_reg.mid_twice    <= sum_reg.mid_twice;
                        if (idx_reg == sum_reg.nres)
                        begin
                            out_reg.kind        <= sum_reg.kind;
                            out_reg.maker_id    <= 32'd0;
                            out_reg.trade_price <= 32'd0;
                            out_reg.trade_qty   <= 32'd0;
                            out_reg.last        <= 1'b1;
                            state_reg           <= RS_IDLE;
                        end
                        else
                        begin
                            out_reg.kind        <= KIND_TRADE;
                            out_reg.maker_id    <= rdata_reg.maker_id;
                            out_reg.trade_price <= rdata_reg.price;
                            out_reg.trade_qty   <= rdata_reg.qty;
                            out_reg.last        <= 1'b0;
                            idx_reg             <= idx_reg + 1'b1;
                            state_reg           <= RS_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= RS_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/limit_order_book_matcher.sv =====
// ============================================================================
// limit_order_book_matcher
// Price-time priority limit order book with trade and status results.
// ============================================================================
// Usage: items arrive on in_valid/in_ready/in_item, one order or cancel per
// item. Each item yields zero or more trade results followed by one status
// result with last set, on out_valid/out_ready/out_item. Every result of an
// item carries the best bid, best ask and their sum (zero while a side is
// empty) as they stand once the item has been fully applied, so the trades
// are buffered and only played out after the book work ends.
// Timing: one item at a time. Book work takes a step for each fill, and the
// sweep ends when a price or the result limit stops it; resting a remainder
// shifts each worse resting order one place back, and a cancel scans every
// resting order on each side. The book memory has a registered read, so
// each step waits for its read data. Results are played out one at a time
// from the trade buffer once the book work ends.
// in_ready rises again once the status result sits in the output register,
// so the next item overlaps with the receiver taking that result.
// Reset empties both sides at once; no clearing pass is needed. A stalled
// receiver holds the current result and play-out simply waits.
// ============================================================================
`default_nettype none

module limit_order_book_matcher #(
    parameter int ORDERS_PER_SIDE = lobm_pkg::ORDERS_PER_SIDE_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lobm_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lobm_pkg::out_item_t      out_item
);
    import lobm_pkg::*;

    trade_wr_t trade_wr;
    summary_t  summary;
    logic      res_idle;

    // Book memory and matching sequencer.
    lobm_engine #(
        .ORDERS_PER_SIDE (ORDERS_PER_SIDE)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .res_idle (res_idle),
        .trade_wr (trade_wr),
        .summary  (summary)
    );

    // Trade buffer and output register.
    lobm_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .trade_wr  (trade_wr),
        .summary   (summary),
        .res_idle  (res_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== sv/lobm_checker.sv =====
// ============================================================================
// lobm_checker
// Port-level checks of the order book matcher, bound to the top level.
// ============================================================================
`default_nettype none

module lobm_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire lobm_pkg::out_item_t out_item
);
    import lobm_pkg::*;

    // One item at a time: an accepted item closes the input for a while.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready straight after an accepted item");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Trades never close an item.
    a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind == KIND_TRADE) |-> !out_item.last)
        else $error("trade marked last");

    // Every status result closes its item.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind != KIND_TRADE) |-> out_item.last)
        else $error("status result not marked last");

    // A non-zero mid is the sum of both best prices.
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.mid_twice != 33'd0) |->
            out_item.mid_twice == ({1'b0, out_item.bid_top} + {1'b0, out_item.ask_top}))
        else $error("mid does not match best prices");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the limit order book matcher. A local book model
// predicts the trades and the status result of every order or cancel; a
// monitor compares each result field by field with the oldest prediction.
// ============================================================================

module tb_top;
    import lobm_pkg::*;

    localparam int DEPTH = ORDERS_PER_SIDE_DEF;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    limit_order_book_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Local copy of the book: index 0 of each side is the best order.
    logic [31:0] bk_bid_px [DEPTH];
    logic [31:0] bk_bid_qt [DEPTH];
    logic [31:0] bk_bid_id [DEPTH];
    int          bk_bid_n;
    logic [31:0] bk_ask_px [DEPTH];
    logic [31:0] bk_ask_qt [DEPTH];
    logic [31:0] bk_ask_id [DEPTH];
    int          bk_ask_n;

    out_item_t pending_results [$];
    int        errors = 0;
    longint    cycles = 0;
    logic      long_stalls;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Random gap length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Removes entry k of one side, closing the hole.
    task automatic remove_at(input logic is_bid, input int k);
        if (is_bid)
        begin
            for (int j = k; j < bk_bid_n - 1; j++)
            begin
                bk_bid_px[j] = bk_bid_px[j+1];
                bk_bid_qt[j] = bk_bid_qt[j+1];
                bk_bid_id[j] = bk_bid_id[j+1];
            end
            bk_bid_n--;
        end
        else
        begin
            for (int j = k; j < bk_ask_n - 1; j++)
            begin
                bk_ask_px[j] = bk_ask_px[j+1];
                bk_ask_qt[j] = bk_ask_qt[j+1];
                bk_ask_id[j] = bk_ask_id[j+1];
            end
            bk_ask_n--;
        end
    endtask

    // Applies one item to the local book and queues the results it causes.
    task automatic book_predict(input in_item_t it);
        out_item_t   batch [$];
        out_item_t   r;
        logic [1:0]  status;
        logic [31:0] rem;
        logic [31:0] p;
        logic [31:0] f;
        logic [31:0] bb;
        logic [31:0] ba;
        logic        is_buy;
        logic        is_mkt;
        logic        more;
        int          k;
        int          pos;
        status = KIND_NONE;
        rem = it.order_qty;
        more = 1'b0;
        is_buy = (it.side == 1'b0);
        is_mkt = (it.action == ACT_MARKET);
        if (it.action == ACT_CANCEL)
        begin
            k = 0;
            while (k < bk_bid_n)
                if (bk_bid_id[k] == it.order_ref) remove_at(1'b1, k); else k++;
            k = 0;
            while (k < bk_ask_n)
                if (bk_ask_id[k] == it.order_ref) remove_at(1'b0, k); else k++;
        end
        else if (it.action == ACT_LIMIT || is_mkt)
        begin
            while (rem != 0 && (is_buy ? bk_ask_n : bk_bid_n) > 0)
            begin
                p = is_buy ? bk_ask_px[0] : bk_bid_px[0];
                if (!is_mkt && (is_buy ? (it.limit_price < p) : (it.limit_price > p)))
                    break;
                if (batch.size() >= MAX_RESULTS - 1)
                begin
                    more = 1'b1;
                    break;
                end
                f = is_buy ? bk_ask_qt[0] : bk_bid_qt[0];
                if (rem < f) f = rem;
                r = '0;
                r.kind = KIND_TRADE;
                r.taker_id = it.order_ref;
                r.maker_id = is_buy ? bk_ask_id[0] : bk_bid_id[0];
                r.trade_side = it.side;
                r.trade_price = p;
                r.trade_qty = f;
                r.trade_time = it.time_ns;
                batch.insert(batch.size(), r);
                rem -= f;
                if (is_buy)
                begin
                    bk_ask_qt[0] -= f;
                    if (bk_ask_qt[0] == 0) remove_at(1'b0, 0);
                end
                else
                begin
                    bk_bid_qt[0] -= f;
                    if (bk_bid_qt[0] == 0) remove_at(1'b1, 0);
                end
            end
            if (rem != 0)
            begin
                if (more)
                    status = KIND_FULL;
                else if (!is_mkt)
                begin
                    if ((is_buy ? bk_bid_n : bk_ask_n) >= DEPTH)
                        status = KIND_FULL;
                    else if (is_buy)
                    begin
                        // Behind every bid priced at or above the new one.
                        pos = 0;
                        while (pos < bk_bid_n && !(bk_bid_px[pos] < it.limit_price)) pos++;
                        for (int j = bk_bid_n; j > pos; j--)
                        begin
                            bk_bid_px[j] = bk_bid_px[j-1];
                            bk_bid_qt[j] = bk_bid_qt[j-1];
                            bk_bid_id[j] = bk_bid_id[j-1];
                        end
                        bk_bid_px[pos] = it.limit_price;
                        bk_bid_qt[pos] = rem;
                        bk_bid_id[pos] = it.order_ref;
                        bk_bid_n++;
                        status = KIND_RESTED;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < bk_ask_n && !(bk_ask_px[pos] > it.limit_price)) pos++;
                        for (int j = bk_ask_n; j > pos; j--)
                        begin
                            bk_ask_px[j] = bk_ask_px[j-1];
                            bk_ask_qt[j] = bk_ask_qt[j-1];
                            bk_ask_id[j] = bk_ask_id[j-1];
                        end
                        bk_ask_px[pos] = it.limit_price;
                        bk_ask_qt[pos] = rem;
                        bk_ask_id[pos] = it.order_ref;
                        bk_ask_n++;
                        status = KIND_RESTED;
                    end
                end
            end
        end
        r = '0;
        r.kind = status;
        r.taker_id = it.order_ref;
        r.trade_side = it.side;
        r.trade_time = it.time_ns;
        r.last = 1'b1;
        batch.insert(batch.size(), r);
        bb = (bk_bid_n > 0) ? bk_bid_px[0] : 32'd0;
        ba = (bk_ask_n > 0) ? bk_ask_px[0] : 32'd0;
        foreach (batch[i])
        begin
            batch[i].bid_top = bb;
            batch[i].ask_top = ba;
            batch[i].mid_twice = (bk_bid_n > 0 && bk_ask_n > 0) ? {1'b0, bb} + {1'b0, ba} : 33'd0;
            pending_results.insert(pending_results.size(), batch[i]);
        end
    endtask

    // Sends one item: presents it at a falling edge and holds it until taken.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_order(input in_item_t it);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        book_predict(it);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_item_t make_order(input logic [1:0] act, input logic sd,
                                            input logic [31:0] px, input logic [31:0] q,
                                            input logic [31:0] id);
        in_item_t it;
        it.action = act;
        it.side = sd;
        it.limit_price = px;
        it.order_qty = q;
        it.order_ref = id;
        it.time_ns = {$urandom, $urandom};
        return it;
    endfunction

    // Receiver: random ready with gaps.
    initial
    begin
        int g;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g > 0 && long_stalls)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no prediction waiting: kind %0d", out_item.kind);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = pending_results.pop_front();
                if (e.kind != out_item.kind)
                begin
                    $error("kind: expected %0d actual %0d", e.kind, out_item.kind); errors++;
                end
                if (e.taker_id != out_item.taker_id)
                begin
                    $error("taker_id: expected %0h actual %0h", e.taker_id, out_item.taker_id);
                    errors++;
                end
                if (e.maker_id != out_item.maker_id)
                begin
                    $error("maker_id: expected %0h actual %0h", e.maker_id, out_item.maker_id);
                    errors++;
                end
                if (e.trade_side != out_item.trade_side)
                begin
                    $error("trade_side: expected %0d actual %0d", e.trade_side,
                           out_item.trade_side);
                    errors++;
                end
                if (e.trade_price != out_item.trade_price)
                begin
                    $error("trade_price: expected %0d actual %0d", e.trade_price,
                           out_item.trade_price);
                    errors++;
                end
                if (e.trade_qty != out_item.trade_qty)
                begin
                    $error("trade_qty: expected %0d actual %0d", e.trade_qty, out_item.trade_qty);
                    errors++;
                end
                if (e.trade_time != out_item.trade_time)
                begin
                    $error("trade_time: expected %0h actual %0h", e.trade_time,
                           out_item.trade_time);
                    errors++;
                end
                if (e.last != out_item.last)
                begin
                    $error("last: expected %0d actual %0d", e.last, out_item.last); errors++;
                end
                if (e.bid_top != out_item.bid_top)
                begin
                    $error("bid_top: expected %0d actual %0d", e.bid_top, out_item.bid_top);
                    errors++;
                end
                if (e.ask_top != out_item.ask_top)
                begin
                    $error("ask_top: expected %0d actual %0d", e.ask_top, out_item.ask_top);
                    errors++;
                end
                if (e.mid_twice != out_item.mid_twice)
                begin
                    $error("mid_twice: expected %0d actual %0d", e.mid_twice,
                           out_item.mid_twice);
                    errors++;
                end
            end
        end
    end

    // Directed: extremes of every field, every action and each special case.
    task automatic test_directed();
        send_order(make_order(ACT_LIMIT, 1'b0, 32'd100, 32'd0, 32'd1));       // zero qty
        send_order(make_order(ACT_MARKET, 1'b0, 32'd0, 32'd5, 32'd2));        // empty book
        send_order(make_order(ACT_CANCEL, 1'b1, 32'd0, 32'd0, 32'd77));       // unknown id
        send_order(make_order(ACT_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_order(make_order(ACT_LIMIT, 1'b0, 32'd100, 32'd10, 32'd10));
        send_order(make_order(ACT_LIMIT, 1'b0, 32'd100, 32'd20, 32'd11));     // same price
        send_order(make_order(ACT_LIMIT, 1'b0, 32'd90, 32'd5, 32'd12));
        send_order(make_order(ACT_LIMIT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_order(make_order(ACT_LIMIT, 1'b1, 32'd95, 32'd25, 32'd13));      // sweep
        send_order(make_order(ACT_MARKET, 1'b0, 32'd0, 32'd3, 32'd14));       // partial
        send_order(make_order(ACT_MARKET, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd15)); // discard
        send_order(make_order(ACT_CANCEL, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_order(make_order(ACT_LIMIT, 1'b1, 32'd0, 32'd1, 32'd0));
        send_order(make_order(ACT_CANCEL, 1'b0, 32'd0, 32'd0, 32'd0));
        // Fill one side completely, then overflow it.
        for (int i = 0; i < DEPTH; i++)
            send_order(make_order(ACT_LIMIT, 1'b0, 32'd50, 32'd1, 32'(500 + i)));
        send_order(make_order(ACT_LIMIT, 1'b0, 32'd40, 32'd1, 32'd600));      // side full
        // Sixty-four makers at one price: the result limit cuts the sweep.
        send_order(make_order(ACT_MARKET, 1'b1, 32'd0, 32'd100, 32'd601));
        send_order(make_order(ACT_CANCEL, 1'b0, 32'd0, 32'd0, 32'd563));
    endtask

    // Random traffic: well-formed orders near one price, some noise.
    task automatic test_random(input int n);
        in_item_t it;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            it.time_ns = {$urandom, $urandom};
            it.side = 1'($urandom_range(0, 1));
            it.order_ref = 32'($urandom_range(0, 40));
            it.limit_price = 32'(32'd1000 + $urandom_range(0, 20) - 10);
            it.order_qty = 32'($urandom_range(1, 30));
            if (r < 60) it.action = ACT_LIMIT;
            else if (r < 75) it.action = ACT_MARKET;
            else if (r < 90) it.action = ACT_CANCEL;
            else
            begin
                it.action = 2'($urandom_range(0, 3));
                it.limit_price = $urandom;
                it.order_qty = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
                it.order_ref = $urandom;
            end
            send_order(it);
        end
    endtask

    initial
    begin
        long_stalls = 1'b0;
        bk_bid_n = 0;
        bk_ask_n = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        long_stalls = 1'b1;
        test_random(290);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
